/* hw/rtl/bta_pkg.sv */
package bta_pkg;

  // Defaults for the top-level parameters
  localparam int REQUESTERS_DEF  = 32;
  localparam int TICKET_BITS_DEF = 16;

  // Fixed field widths on the ports
  localparam int REQ_W       = 5;
  localparam int OUT_TKT_W   = 16;
  localparam int GRANT_ID_W  = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Bit positions inside out_tdata
  localparam int OUT_GV_BIT  = OUT_TKT_W;
  localparam int OUT_GID_LSB = OUT_TKT_W + 1;

  // Item kinds carried on in_tuser
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MERGE
  } state_t;

  // Control for one step of the shared scan unit
  typedef struct packed {
    logic elem_vld;  // element present this step
    logic skip;      // leave element out of the grant search
    logic merge;     // final step: element is the updated ticket, no max update
  } scan_ctl_t;

endpackage

/* hw/rtl/bta_ticket_mem.sv */
module bta_ticket_mem #(
  parameter int REQUESTERS  = bta_pkg::REQUESTERS_DEF,
  parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [$clog2(REQUESTERS)-1:0]   rd_addr,
  output logic [TICKET_BITS-1:0]          rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(REQUESTERS)-1:0]   wr_addr,
  input  logic [TICKET_BITS-1:0]          wr_data
);
  import bta_pkg::*;

  logic [TICKET_BITS-1:0] mem [REQUESTERS];
  logic [REQUESTERS-1:0]  vld_r;
  logic [TICKET_BITS-1:0] rd_q_r;
  logic                   rd_vld_r;

  // Write the ticket store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; reset marks every requester idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Unwritten entries read as idle
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

/* hw/rtl/bta_scan_unit.sv */
module bta_scan_unit #(
  parameter int REQUESTERS  = bta_pkg::REQUESTERS_DEF,
  parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
  input  bta_pkg::scan_ctl_t              ctl,
  input  logic [TICKET_BITS-1:0]          elem_tkt,
  input  logic [$clog2(REQUESTERS)-1:0]   elem_idx,
  input  logic [TICKET_BITS-1:0]          max_in,
  input  logic                            found_in,
  input  logic [TICKET_BITS-1:0]          best_in,
  input  logic [$clog2(REQUESTERS)-1:0]   who_in,
  output logic [TICKET_BITS-1:0]          max_out,
  output logic                            found_out,
  output logic [TICKET_BITS-1:0]          best_out,
  output logic [$clog2(REQUESTERS)-1:0]   who_out
);
  import bta_pkg::*;

  logic take_max;
  logic take_min;

  // Running maximum over all held tickets
  assign take_max = ctl.elem_vld && !ctl.merge && (elem_tkt > max_in);
  assign max_out  = take_max ? elem_tkt : max_in;

  // Lowest nonzero ticket, ties to the lower index
  always_comb begin
    take_min = ctl.elem_vld && !ctl.skip && (elem_tkt != '0) &&
               (!found_in || (elem_tkt < best_in) ||
                ((elem_tkt == best_in) && (elem_idx < who_in)));
    found_out = found_in || take_min;
    best_out  = take_min ? elem_tkt : best_in;
    who_out   = take_min ? elem_idx : who_in;
  end

endmodule

/* hw/rtl/bakery_ticket_arbiter_top.sv */
// Channel  Ports                          Contents (lowest bit first)
// in       in_tvalid/in_tready/in_tdata   tdata: requester[4:0], zero pad; tuser: func
// out      out_tvalid/out_tready/out_tdata tdata: ticket[15:0], grant_valid, grant_id[4:0],
//                                          zero pad; tuser: status
//
// The shared scan unit visits one stored ticket per cycle through the single registered
// read port, then a drain step takes in the last read and one merge step folds in the
// updated ticket. The result becomes valid as the merge step completes, and in_tready
// rises in the same cycle, so a new beat is taken only after the previous item's merge
// step. in_tready is high only while the sequencer is idle. A result waiting on
// out_tready stalls only the merge step of the next item. Reset (rst_n low, synchronous)
// marks all requesters idle at once.
module bakery_ticket_arbiter_top #(
  parameter int REQUESTERS  = bta_pkg::REQUESTERS_DEF,
  parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bta_pkg::IN_TDATA_W-1:0]   in_tdata,   // requester[4:0], pad[7:5]
  input  logic                             in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bta_pkg::OUT_TDATA_W-1:0]  out_tdata,  // ticket[15:0], grant_valid[16],
                                                       // grant_id[21:17], pad[23:22]
  output logic                             out_tuser   // status
);
  import bta_pkg::*;

  localparam int IDX_W = $clog2(REQUESTERS);
  localparam int CNT_W = $clog2(REQUESTERS + 1);
  localparam logic [TICKET_BITS-1:0] TOP_TKT = '1;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic                   func_r;
  logic [REQ_W-1:0]       req_r;
  logic                   inrange_r;
  logic                   rd_pend_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [TICKET_BITS-1:0] max_r, best_r;
  logic                   found_r;
  logic [IDX_W-1:0]       who_r;

  logic                   out_valid_r;
  logic [OUT_TKT_W-1:0]   out_tkt_r;
  logic                   out_gv_r;
  logic [GRANT_ID_W-1:0]  out_gid_r;
  logic                   out_status_r;

  logic                   in_fire;
  logic                   in_range;
  logic                   rd_en;
  logic                   acc_en;
  logic                   merge_st;
  logic                   merge_en;
  logic [IDX_W-1:0]       req_idx;
  logic [TICKET_BITS-1:0] rd_data;
  logic [TICKET_BITS-1:0] new_tkt;
  logic                   sat;

  scan_ctl_t              ctl;
  logic [TICKET_BITS-1:0] elem_tkt;
  logic [IDX_W-1:0]       elem_idx;
  logic [TICKET_BITS-1:0] max_o, best_o;
  logic                   found_o;
  logic [IDX_W-1:0]       who_o;

  assign in_fire  = in_tvalid && in_tready;
  assign in_range = int'(in_tdata[REQ_W-1:0]) < REQUESTERS;
  assign req_idx  = IDX_W'(req_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == CNT_W'(REQUESTERS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_MERGE;
      ST_MERGE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    acc_en    = 1'b0;
    merge_st  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SCAN: begin
        rd_en  = 1'b1;
        acc_en = 1'b1;
      end
      ST_DRAIN: acc_en = 1'b1;
      ST_MERGE: merge_st = 1'b1;
      default: ;
    endcase
    merge_en = merge_st && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item and step the scan address
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= in_tuser;
      req_r     <= in_tdata[REQ_W-1:0];
      inrange_r <= in_range;
      cnt_r     <= '0;
    end else if (rd_en) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
    end
    rd_idx_r <= cnt_r[IDX_W-1:0];
  end

  bta_ticket_mem #(
    .REQUESTERS  (REQUESTERS),
    .TICKET_BITS (TICKET_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (merge_en && inrange_r),
    .wr_addr (req_idx),
    .wr_data (new_tkt)
  );

  // New ticket for the requester: one above the largest, saturating; zero on release
  assign sat     = (func_r == FUNC_REQUEST) && (max_r == TOP_TKT);
  assign new_tkt = (func_r == FUNC_RELEASE) ? '0 :
                   (sat ? TOP_TKT : max_r + TICKET_BITS'(1));

  // Feed the shared unit: stored tickets during the scan, the new ticket at merge
  always_comb begin
    ctl.merge    = merge_st;
    ctl.elem_vld = merge_st ? inrange_r : rd_pend_r;
    ctl.skip     = !merge_st && inrange_r && (rd_idx_r == req_idx);
    elem_tkt     = merge_st ? new_tkt : rd_data;
    elem_idx     = merge_st ? req_idx : rd_idx_r;
  end

  bta_scan_unit #(
    .REQUESTERS  (REQUESTERS),
    .TICKET_BITS (TICKET_BITS)
  ) u_scan (
    .ctl       (ctl),
    .elem_tkt  (elem_tkt),
    .elem_idx  (elem_idx),
    .max_in    (max_r),
    .found_in  (found_r),
    .best_in   (best_r),
    .who_in    (who_r),
    .max_out   (max_o),
    .found_out (found_o),
    .best_out  (best_o),
    .who_out   (who_o)
  );

  // Clear the accumulators on accept, advance them each scan step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      max_r   <= '0;
      found_r <= 1'b0;
      best_r  <= '0;
      who_r   <= '0;
    end else if (acc_en) begin
      max_r   <= max_o;
      found_r <= found_o;
      best_r  <= best_o;
      who_r   <= who_o;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_en) begin
      out_tkt_r    <= inrange_r ? OUT_TKT_W'(new_tkt) : '0;
      out_status_r <= inrange_r && sat;
      out_gv_r     <= found_o;
      out_gid_r    <= found_o ? GRANT_ID_W'(who_o) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_TKT_W - 1 - GRANT_ID_W){1'b0}},
                       out_gid_r, out_gv_r, out_tkt_r};
  assign out_tuser  = out_status_r;

endmodule

/* hw/rtl/bta_checker.sv */
module bta_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [bta_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bta_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import bta_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Block is busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again during scan");

  // No grant means grant id zero
  a_gid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_GV_BIT] |-> out_tdata[OUT_GID_LSB +: GRANT_ID_W] == '0)
    else $error("grant id set without a grant");

  // A held or saturated ticket implies a grant
  a_tkt_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser || (out_tdata[OUT_TKT_W-1:0] != '0)) |-> out_tdata[OUT_GV_BIT])
    else $error("ticket held but no grant reported");

endmodule

bind bakery_ticket_arbiter_top bta_checker u_bta_checker (.*);

/* tb/bakery_ticket_arbiter_top_test.sv */
module bakery_ticket_arbiter_top_test;
  import bta_pkg::*;

  // Full-width tickets as the block is built by default
  localparam int REQUESTERS   = REQUESTERS_DEF;
  localparam int TKT_BITS     = TICKET_BITS_DEF;
  localparam logic [TKT_BITS-1:0] TOP_TICKET = {TKT_BITS{1'b1}};
  localparam int CLIMB_ITEMS  = 200;
  localparam int RANDOM_ITEMS = 320;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * (REQUESTERS + 3);
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [OUT_TKT_W-1:0]  ticket;
    logic                  grant_valid;
    logic [GRANT_ID_W-1:0] grant_id;
    logic                  status;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = FUNC_REQUEST;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Predictor state: one ticket per requester, zero when idle
  logic [TKT_BITS-1:0] tickets_held [REQUESTERS];
  grant_t              pending_grants [$];
  int unsigned         bad_grants = 0;
  int unsigned         cycle_count = 0;

  // Idling and hold-off controls
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  bakery_ticket_arbiter_top #(
    .REQUESTERS  (REQUESTERS),
    .TICKET_BITS (TKT_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request or release to the ticket table, return the grant it reports
  function automatic grant_t predict_grant(input logic func, input logic [REQ_W-1:0] who);
    grant_t              r;
    logic [TKT_BITS-1:0] top_held;
    logic [TKT_BITS-1:0] best;
    r = '0;
    if (int'(who) < REQUESTERS) begin
      if (func == FUNC_REQUEST) begin
        top_held = '0;
        foreach (tickets_held[i]) if (tickets_held[i] > top_held) top_held = tickets_held[i];
        if (top_held == TOP_TICKET) begin
          tickets_held[who] = TOP_TICKET;
          r.status = 1'b1;
        end else begin
          tickets_held[who] = top_held + 1'b1;
        end
        r.ticket = OUT_TKT_W'(tickets_held[who]);
      end else begin
        tickets_held[who] = '0;
      end
    end
    // lowest nonzero ticket wins, ties to the lower index
    best = '0;
    for (int i = 0; i < REQUESTERS; i++) begin
      if (tickets_held[i] != '0 && (!r.grant_valid || tickets_held[i] < best)) begin
        r.grant_valid = 1'b1;
        r.grant_id    = i[GRANT_ID_W-1:0];
        best          = tickets_held[i];
      end
    end
    return r;
  endfunction

  // Offer one beat, wait for it to be taken, then record the grant it must produce
  task automatic send_item(input logic func, input logic [REQ_W-1:0] who);
    grant_t want;
    if (src_idle && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_TDATA_W-REQ_W){1'b0}}, who};
    do @(posedge clk); while (!in_tready);
    want = predict_grant(func, who);
    pending_grants.push_back(want);
  endtask

  // Stop offering and wait for every outstanding grant, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_grant(input logic [OUT_TDATA_W-1:0] data, input logic flag);
    grant_t got;
    grant_t want;
    got.ticket      = data[OUT_TKT_W-1:0];
    got.grant_valid = data[OUT_GV_BIT];
    got.grant_id    = data[OUT_GID_LSB +: GRANT_ID_W];
    got.status      = flag;
    if (pending_grants.size() == 0) begin
      bad_grants++;
      if (bad_grants <= 10)
        $display("unexpected result beat: ticket %0d valid %0b id %0d status %0b",
                 got.ticket, got.grant_valid, got.grant_id, got.status);
    end else begin
      want = pending_grants.pop_front();
      if (got.ticket !== want.ticket || got.grant_valid !== want.grant_valid ||
          got.grant_id !== want.grant_id || got.status !== want.status) begin
        bad_grants++;
        if (bad_grants <= 10)
          $display({"mismatch: exp ticket %0d valid %0b id %0d status %0b, ",
                    "got ticket %0d valid %0b id %0d status %0b"},
                   want.ticket, want.grant_valid, want.grant_id, want.status,
                   got.ticket, got.grant_valid, got.grant_id, got.status);
      end
    end
  endtask

  // Check each accepted result beat and drive out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_grant(out_tdata, out_tuser);
    if (hold_trig != hold_seen) begin
      hold_seen  <= hold_trig;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(sink_idle && $urandom_range(99) < 38);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Fresh tickets, repeated requests, idle releases and the no-grant case
  task automatic test_request_release();
    send_item(FUNC_REQUEST, 5'd0);
    send_item(FUNC_REQUEST, 5'd31);
    send_item(FUNC_REQUEST, 5'd0);
    send_item(FUNC_REQUEST, 5'd16);
    send_item(FUNC_RELEASE, 5'd31);
    send_item(FUNC_RELEASE, 5'd0);
    send_item(FUNC_RELEASE, 5'd5);
    send_item(FUNC_RELEASE, 5'd16);
    send_item(FUNC_RELEASE, 5'd16);
    send_item(FUNC_REQUEST, 5'd21);
    send_item(FUNC_REQUEST, 5'd10);
    send_item(FUNC_RELEASE, 5'd21);
    send_item(FUNC_RELEASE, 5'd10);
  endtask

  // Climb tickets with two alternating holders, then order several holders by ticket
  task automatic test_ticket_climb();
    for (int k = 0; k < CLIMB_ITEMS; k++)
      send_item(FUNC_REQUEST, (k % 2) ? 5'd31 : 5'd30);
    send_item(FUNC_REQUEST, 5'd7);
    send_item(FUNC_REQUEST, 5'd3);
    send_item(FUNC_REQUEST, 5'd3);
    send_item(FUNC_RELEASE, 5'd30);
    send_item(FUNC_RELEASE, 5'd31);
    send_item(FUNC_RELEASE, 5'd3);
    send_item(FUNC_RELEASE, 5'd7);
    send_item(FUNC_REQUEST, 5'd7);
    send_item(FUNC_RELEASE, 5'd7);
  endtask

  // Hold off the receiver while items keep coming, then pause until all grants are back
  task automatic test_backpressure();
    src_idle = 1'b0;
    hold_trig <= ~hold_trig;
    for (int k = 0; k < 8; k++)
      send_item(1'($urandom_range(1)), REQ_W'($urandom_range(REQUESTERS - 1)));
    src_idle = 1'b1;
    settle();
  endtask

  // Mostly request/release of holders with periodic full release; some noise
  task automatic test_random_traffic();
    int  holders[$];
    int  sent;
    int  next_flush;
    int  roll;
    bit  quiet;
    sent = 0;
    next_flush = $urandom_range(15, 500);
    while (sent < RANDOM_ITEMS) begin
      // no idling on either side in the middle stretch
      quiet = (sent >= 120 && sent < 240);
      src_idle = !quiet;
      sink_idle <= !quiet;
      holders.delete();
      foreach (tickets_held[i]) if (tickets_held[i] != '0) holders.push_back(i);
      if (sent >= next_flush) begin
        foreach (holders[k]) begin
          send_item(FUNC_RELEASE, REQ_W'(holders[k]));
          sent++;
        end
        next_flush = sent + $urandom_range(15, 500);
      end else begin
        roll = $urandom_range(99);
        if (roll < 12)
          send_item(1'($urandom_range(1)), REQ_W'($urandom_range(REQUESTERS - 1)));
        else if (roll < 50 && holders.size() != 0)
          send_item(FUNC_RELEASE, REQ_W'(holders[$urandom_range(holders.size() - 1)]));
        else
          send_item(FUNC_REQUEST, REQ_W'($urandom_range(REQUESTERS - 1)));
        sent++;
      end
    end
    src_idle = 1'b1;
    sink_idle <= 1'b1;
  endtask

  initial begin
    foreach (tickets_held[i]) tickets_held[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_request_release();
    test_ticket_climb();
    test_backpressure();
    test_random_traffic();
    settle();
    if (bad_grants == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bta_pkg.sv
hw/rtl/bta_ticket_mem.sv
hw/rtl/bta_scan_unit.sv
hw/rtl/bakery_ticket_arbiter_top.sv
hw/rtl/bta_checker.sv
tb/bakery_ticket_arbiter_top_test.sv
